/* sv/wstf_pkg.sv */
package wstf_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int CFG_ADDR_W     = 5;

  typedef enum logic [2:0] {
    REG_MEAN_LIMIT   = 3'd0,
    REG_STD_LIMIT    = 3'd1,
    REG_REL_LIMIT    = 3'd2,
    REG_RANGE_LIMIT  = 3'd3,
    REG_SUM_LIMIT    = 3'd4,
    REG_HIGH_SCORE   = 3'd5,
    REG_LOW_SCORE    = 3'd6,
    REG_NONE         = 3'd7
  } reg_idx_t;

  localparam logic signed [15:0] HIGH_SCORE_RST = 16'sd256;
  localparam logic signed [15:0] SAMPLE_MAX     = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN     = 16'sh8000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN,
    S_MEAN_W,
    S_MULA,
    S_MULB,
    S_SUB,
    S_VAR_W,
    S_SQRT,
    S_CV,
    S_CV_W,
    S_FIN
  } seq_state_t;

endpackage

/* sv/wstf_acc.sv */
module wstf_acc #(
  parameter int MAX_WINDOW = wstf_pkg::MAX_WINDOW_DEF,
  parameter int CNT_W      = 7,
  parameter int SUM_W      = 23,
  parameter int SQ_W       = 38
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    take,
  input  logic                    clear,
  input  logic signed [15:0]      sample,
  output logic [CNT_W-1:0]        count,
  output logic signed [SUM_W-1:0] sum,
  output logic [SQ_W-1:0]         sumsq,
  output logic signed [15:0]      min_val,
  output logic signed [15:0]      max_val,
  output logic                    ovf
);

  logic [CNT_W-1:0]        count_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]         sumsq_r;
  logic signed [15:0]      min_r;
  logic signed [15:0]      max_r;
  logic                    ovf_r;
  logic signed [31:0]      sq;

  assign sq = sample * sample;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      count_r <= '0;
      sum_r   <= '0;
      sumsq_r <= '0;
      min_r   <= wstf_pkg::SAMPLE_MAX;
      max_r   <= wstf_pkg::SAMPLE_MIN;
      ovf_r   <= 1'b0;
    end else if (take) begin
      if (count_r < CNT_W'(MAX_WINDOW)) begin
        count_r <= count_r + CNT_W'(1);
        sum_r   <= sum_r + SUM_W'(sample);
        sumsq_r <= sumsq_r + SQ_W'($unsigned(sq[30:0]));
        if (sample < min_r) min_r <= sample;
        if (sample > max_r) max_r <= sample;
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  assign count   = count_r;
  assign sum     = sum_r;
  assign sumsq   = sumsq_r;
  assign min_val = min_r;
  assign max_val = max_r;
  assign ovf     = ovf_r;

endmodule

/* sv/wstf_div.sv */
module wstf_div #(
  parameter int DW = 45
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic          rem_nz
);

  localparam int STEP_W = $clog2(DW + 1);

  logic [DW:0]       rem_r;
  logic [DW-1:0]     quo_r;
  logic [DW-1:0]     dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DW:0]       rem_sh;
  logic              fits;

  assign rem_sh = {rem_r[DW-1:0], quo_r[DW-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DW);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quo_r <= {quo_r[DW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
  assign rem_nz   = rem_r != '0;

endmodule

/* sv/window_stats_threshold_features_top.sv */
// Channel | Handshake           | Payload
// in      | in_valid/in_ready   | in_sample, in_last_sample
// out     | out_valid/out_ready | mean, variance, std, relative, range, flags, sum, count, status
// cfg     | psel/penable/pwrite | paddr, pwdata, prdata, pready
// A sample without the last mark is accumulated in idle, and the next sample can follow directly.
// A last sample runs the window sequencer: three passes of the shared
// restoring divider, two shift-add products, a 16-step square root and
// control states, up to the record load.
// A single-sample window skips the variance pass, a zero mean skips the cv pass.
// The record waits in the output register; the next window runs meanwhile,
// and the sequencer holds in its last state while that register is still full.
// Reset is synchronous: registers to their reset values, accumulators cleared.
module window_stats_threshold_features_top #(
  parameter int MAX_WINDOW = wstf_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [15:0]              in_sample,
  input  logic                            in_last_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [15:0]              out_mean_value,
  output logic [31:0]                     out_variance_value,
  output logic [15:0]                     out_std_value,
  output logic signed [15:0]              out_relative_value,
  output logic [15:0]                     out_range_value,
  output logic [4:0]                      out_confidence_flags,
  output logic signed [17:0]              out_score_sum,
  output logic [2:0]                      out_overpass_count,
  output logic [2:0]                      out_status_bits,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wstf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = 16 + CNT_W;
  localparam int SQ_W   = 31 + CNT_W;
  localparam int NUM_W  = SQ_W + CNT_W;
  localparam int STEP_W = $clog2(SUM_W + 1);

  // configuration
  logic signed [15:0] mean_lim_r, rel_lim_r, high_r, low_r;
  logic [15:0]        std_lim_r, range_lim_r;
  logic signed [17:0] sum_lim_r;
  wstf_pkg::reg_idx_t ridx;

  assign ridx   = wstf_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_lim_r  <= '0;
      std_lim_r   <= '0;
      rel_lim_r   <= '0;
      range_lim_r <= '0;
      sum_lim_r   <= '0;
      high_r      <= wstf_pkg::HIGH_SCORE_RST;
      low_r       <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        wstf_pkg::REG_MEAN_LIMIT:  mean_lim_r  <= pwdata[15:0];
        wstf_pkg::REG_STD_LIMIT:   std_lim_r   <= pwdata[15:0];
        wstf_pkg::REG_REL_LIMIT:   rel_lim_r   <= pwdata[15:0];
        wstf_pkg::REG_RANGE_LIMIT: range_lim_r <= pwdata[15:0];
        wstf_pkg::REG_SUM_LIMIT:   sum_lim_r   <= pwdata[17:0];
        wstf_pkg::REG_HIGH_SCORE:  high_r      <= pwdata[15:0];
        wstf_pkg::REG_LOW_SCORE:   low_r       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      wstf_pkg::REG_MEAN_LIMIT:  prdata = 32'($unsigned(mean_lim_r));
      wstf_pkg::REG_STD_LIMIT:   prdata = 32'(std_lim_r);
      wstf_pkg::REG_REL_LIMIT:   prdata = 32'($unsigned(rel_lim_r));
      wstf_pkg::REG_RANGE_LIMIT: prdata = 32'(range_lim_r);
      wstf_pkg::REG_SUM_LIMIT:   prdata = 32'($unsigned(sum_lim_r));
      wstf_pkg::REG_HIGH_SCORE:  prdata = 32'($unsigned(high_r));
      wstf_pkg::REG_LOW_SCORE:   prdata = 32'($unsigned(low_r));
      default:                   prdata = '0;
    endcase
  end

  // accumulators
  wstf_pkg::seq_state_t st_r, st_nxt;
  logic                    take, clear;
  logic [CNT_W-1:0]        cnt;
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sumsq;
  logic signed [15:0]      min_v, max_v;
  logic                    ovf;

  assign in_ready = st_r == wstf_pkg::S_IDLE;
  assign take     = in_valid && in_ready;

  wstf_acc #(
    .MAX_WINDOW(MAX_WINDOW), .CNT_W(CNT_W), .SUM_W(SUM_W), .SQ_W(SQ_W)
  ) u_acc (
    .clk(clk), .rst_n(rst_n), .take(take), .clear(clear), .sample(in_sample),
    .count(cnt), .sum(sum), .sumsq(sumsq), .min_val(min_v), .max_val(max_v), .ovf(ovf)
  );

  // shared divider
  logic             div_start, div_done, div_nz;
  logic [NUM_W-1:0] div_a, div_b, div_q;
  logic [SUM_W-1:0] abs_s;
  logic [16:0]      abs_m;
  logic [NUM_W-1:0] den;
  logic [2*CNT_W-1:0] den_p;

  wstf_div #(.DW(NUM_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q), .rem_nz(div_nz)
  );

  // sequencer registers
  logic [NUM_W-1:0]   num_r, num_nxt, p_r, p_nxt;
  logic [SUM_W-1:0]   mul_r, mul_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic signed [15:0] mean_r, mean_nxt, rel_r, rel_nxt;
  logic [31:0]        var_r, var_nxt;
  logic [15:0]        sd_r, sd_nxt, sq_t;
  logic [3:0]         sb_r, sb_nxt;
  logic [31:0]        sq_p;
  logic [NUM_W:0]     mag;
  logic               load_out;

  logic [3:0]         fl4;
  logic signed [17:0] ssum;
  logic [4:0]         flags;
  logic [16:0]        range_d;

  assign abs_s   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign abs_m   = mean_r[15] ? 17'(-(17'(mean_r))) : 17'(mean_r);
  assign den_p   = {CNT_W'(0), cnt} * {CNT_W'(0), cnt - CNT_W'(1)};
  assign den     = NUM_W'(den_p);
  assign sq_t    = sd_r | (16'h1 << sb_r);
  assign sq_p    = sq_t * sq_t;
  assign mag     = (NUM_W + 1)'(div_q) + (NUM_W + 1)'(div_nz);
  assign range_d = 17'(max_v) - 17'(min_v);

  always_comb begin
    fl4[0] = mean_r > mean_lim_r;
    fl4[1] = sd_r > std_lim_r;
    fl4[2] = rel_r > rel_lim_r;
    fl4[3] = range_d[15:0] > range_lim_r;
    ssum = '0;
    for (int i = 0; i < 4; i++) begin
      ssum = ssum + (fl4[i] ? 18'(high_r) : 18'(low_r));
    end
    flags = {ssum > sum_lim_r, fl4};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= wstf_pkg::S_IDLE;
    else        st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    p_r    <= p_nxt;
    mul_r  <= mul_nxt;
    step_r <= step_nxt;
    mean_r <= mean_nxt;
    rel_r  <= rel_nxt;
    var_r  <= var_nxt;
    sd_r   <= sd_nxt;
    sb_r   <= sb_nxt;
  end

  always_comb begin
    st_nxt    = st_r;
    num_nxt   = num_r;
    p_nxt     = p_r;
    mul_nxt   = mul_r;
    step_nxt  = step_r;
    mean_nxt  = mean_r;
    rel_nxt   = rel_r;
    var_nxt   = var_r;
    sd_nxt    = sd_r;
    sb_nxt    = sb_r;
    div_start = 1'b0;
    div_a     = NUM_W'(abs_s);
    div_b     = NUM_W'(cnt);
    clear     = 1'b0;
    load_out  = 1'b0;
    unique case (st_r)
      wstf_pkg::S_IDLE: begin
        if (take && in_last_sample) st_nxt = wstf_pkg::S_MEAN;
      end
      wstf_pkg::S_MEAN: begin
        div_start = 1'b1;
        st_nxt    = wstf_pkg::S_MEAN_W;
      end
      wstf_pkg::S_MEAN_W: begin
        if (div_done) begin
          mean_nxt = sum[SUM_W-1] ? 16'(-mag) : 16'(div_q);
          num_nxt  = '0;
          mul_nxt  = SUM_W'(cnt);
          step_nxt = '0;
          st_nxt   = wstf_pkg::S_MULA;
        end
      end
      wstf_pkg::S_MULA: begin
        num_nxt  = (num_r << 1) + (mul_r[SUM_W-1] ? NUM_W'(sumsq) : '0);
        mul_nxt  = mul_r << 1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          p_nxt    = '0;
          mul_nxt  = abs_s;
          step_nxt = '0;
          st_nxt   = wstf_pkg::S_MULB;
        end
      end
      wstf_pkg::S_MULB: begin
        p_nxt    = (p_r << 1) + (mul_r[SUM_W-1] ? NUM_W'(abs_s) : '0);
        mul_nxt  = mul_r << 1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) st_nxt = wstf_pkg::S_SUB;
      end
      wstf_pkg::S_SUB: begin
        num_nxt = num_r - p_r;
        sd_nxt  = '0;
        sb_nxt  = 4'd15;
        if (cnt < CNT_W'(2)) begin
          var_nxt = '0;
          st_nxt  = wstf_pkg::S_SQRT;
        end else begin
          st_nxt = wstf_pkg::S_VAR_W;
        end
      end
      wstf_pkg::S_VAR_W: begin
        div_a     = num_r;
        div_b     = den;
        div_start = !div_done;
        if (div_done) begin
          var_nxt = (div_q > NUM_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : div_q[31:0];
          st_nxt  = wstf_pkg::S_SQRT;
        end
      end
      wstf_pkg::S_SQRT: begin
        if (sq_p <= var_r) sd_nxt = sq_t;
        sb_nxt = sb_r - 4'd1;
        if (sb_r == 4'd0) st_nxt = wstf_pkg::S_CV;
      end
      wstf_pkg::S_CV: begin
        div_a = NUM_W'({sd_r, 8'h00});
        div_b = NUM_W'(abs_m);
        if (mean_r == '0) begin
          rel_nxt = '0;
          st_nxt  = wstf_pkg::S_FIN;
        end else begin
          div_start = 1'b1;
          st_nxt    = wstf_pkg::S_CV_W;
        end
      end
      wstf_pkg::S_CV_W: begin
        if (div_done) begin
          if (!mean_r[15]) begin
            rel_nxt = (div_q > NUM_W'(32767)) ? 16'sh7FFF : 16'(div_q);
          end else begin
            rel_nxt = (mag > (NUM_W + 1)'(32768)) ? 16'sh8000 : 16'(-mag);
          end
          st_nxt = wstf_pkg::S_FIN;
        end
      end
      wstf_pkg::S_FIN: begin
        if (!out_valid || out_ready) begin
          load_out = 1'b1;
          clear    = 1'b1;
          st_nxt   = wstf_pkg::S_IDLE;
        end
      end
      default: st_nxt = wstf_pkg::S_IDLE;
    endcase
  end

  // output register
  logic ov_r;
  always_ff @(posedge clk) begin
    if (!rst_n)              ov_r <= 1'b0;
    else if (load_out)       ov_r <= 1'b1;
    else if (out_ready)      ov_r <= 1'b0;
  end
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_mean_value       <= mean_r;
      out_variance_value   <= var_r;
      out_std_value        <= sd_r;
      out_relative_value   <= rel_r;
      out_range_value      <= range_d[15:0];
      out_confidence_flags <= flags;
      out_score_sum        <= ssum;
      out_overpass_count   <= 3'($countones(flags));
      out_status_bits      <= {ovf, mean_r == '0, cnt < CNT_W'(2)};
    end
  end

endmodule
